>>> hdl/adnp_pkg.sv
// ----------------------------------------------------------------------------
// adnp_pkg
// Shared types, constants and helpers of the decimal number parser.
// ----------------------------------------------------------------------------
package adnp_pkg;

    // Width of the internal accumulator (wrap and overflow refer to it).
    localparam int VALUE_BITS = 32;

    // Classified-item queue between the byte front and the parser back.
    // The depth must be a power of two.
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Parse phases
    localparam logic [1:0] PH_LEADER = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_TRAILS = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_DIGIT = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    // Variant codes
    localparam logic [1:0] VAR_SKIP_TRAIL = 2'd0;
    localparam logic [1:0] VAR_STOP_SPACE = 2'd1;
    localparam logic [1:0] VAR_COMMENTS   = 2'd2;

    // Character codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_data;
    } in_t;

    typedef struct packed {
        logic [31:0] number_value;
        logic [1:0]  parse_status;
        logic        overflowed;
        logic        last_of_run;
    } out_t;

    // Byte after classification
    typedef struct packed {
        logic       eod;
        logic       is_space;
        logic       is_digit;
        logic       is_hash;
        logic       is_newline;
        logic [3:0] digit;
    } cls_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic pend_valid;
        logic take;
    } back_status_t;

    // Low 32 bits of the accumulator, zero-extended when it is narrower.
    function automatic logic [31:0] low_word(input logic [VALUE_BITS-1:0] acc);
        logic [63:0] wide;
        wide = 64'(acc);
        return wide[31:0];
    endfunction

    function automatic out_t make_result(input logic [31:0] value,
                                         input logic [1:0]  status,
                                         input logic        ovf,
                                         input logic        last);
        out_t r;
        r.number_value = value;
        r.parse_status = status;
        r.overflowed   = ovf;
        r.last_of_run  = last;
        return r;
    endfunction

endpackage

>>> hdl/ascii_decimal_number_parser.sv
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser
// Streaming parser of whitespace-separated unsigned decimal numbers.
// ----------------------------------------------------------------------------
// Path: an accepted byte waits in the queue and is then parsed straight
//   into the parser's output register when the back takes it.
// Throughput: one byte per cycle unless results back up; a byte that yields
//   two results holds the parser until the second enters the output register.
// Reset (rst_n, async, active low): parser idle, queue empty, variant 0.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser (
    input  logic           clk,
    input  logic           rst_n,
    // byte transactions
    input  logic           byte_valid,
    output logic           byte_ready,
    input  adnp_pkg::in_t  byte_item,
    // result transactions
    output logic           result_valid,
    input  logic           result_ready,
    output adnp_pkg::out_t result_item,
    // configuration
    input  logic           cfg_write_en,
    input  logic [1:0]     cfg_write_data
);

    logic [1:0]              variant_reg;
    adnp_pkg::cls_t          front_cls;
    adnp_pkg::cls_t          queue_head;
    logic                    queue_valid;
    logic                    back_ready;
    adnp_pkg::queue_status_t queue_status;
    adnp_pkg::back_status_t  back_status;

    // Variant register: the user is to write it only while the parser is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= adnp_pkg::VAR_SKIP_TRAIL;
        end
        else if (cfg_write_en)
        begin
            variant_reg <= cfg_write_data;
        end
    end

    // Front: classify the byte; it enters the queue in the same cycle
    adnp_front u_front (
        .item (byte_item),
        .cls  (front_cls)
    );

    // Queue: decouple byte intake from parsing so either side may stall
    adnp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (byte_valid),
        .push_ready (byte_ready),
        .push_data  (front_cls),
        .pop_valid  (queue_valid),
        .pop_ready  (back_ready),
        .pop_data   (queue_head),
        .status     (queue_status)
    );

    // Back: advance the parse phase, accumulate digits, emit results
    adnp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .variant      (variant_reg),
        .item_valid   (queue_valid),
        .item_ready   (back_ready),
        .item         (queue_head),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_item),
        .status       (back_status)
    );

    // Queue can never be full and empty at once
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_status.full && queue_status.empty))
        else $error("queue reports full and empty together");

    // A held second result implies the first still occupies the output
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pend_valid |-> (result_valid && !result_item.last_of_run))
        else $error("second result pending without first result shown");

    // The parser never takes a transaction while a second result waits
    a_no_take_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        back_status.pend_valid |-> !back_status.take)
        else $error("parser took a transaction with a result pending");

endmodule

>>> hdl/adnp_front.sv
// ----------------------------------------------------------------------------
// adnp_front
// Byte classifier: tags each incoming byte as space, digit, hash or newline.
// ----------------------------------------------------------------------------
module adnp_front (
    input  adnp_pkg::in_t  item,
    output adnp_pkg::cls_t cls
);

    logic [7:0] b;

    assign b = item.byte_in;

    always_comb
    begin
        cls.eod        = item.end_of_data;
        cls.is_space   = (b inside {[adnp_pkg::CH_TAB:adnp_pkg::CH_CR], adnp_pkg::CH_SPACE});
        cls.is_digit   = (b inside {[adnp_pkg::CH_ZERO:adnp_pkg::CH_NINE]});
        cls.is_hash    = (b == adnp_pkg::CH_HASH);
        cls.is_newline = (b == adnp_pkg::CH_NEWLINE);
        cls.digit      = 4'(b - adnp_pkg::CH_ZERO);
    end

endmodule

>>> hdl/adnp_queue.sv
// ----------------------------------------------------------------------------
// adnp_queue
// Short FIFO of classified bytes between the front and the parser back.
// ----------------------------------------------------------------------------
module adnp_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  adnp_pkg::cls_t          push_data,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output adnp_pkg::cls_t          pop_data,
    output adnp_pkg::queue_status_t status
);

    adnp_pkg::cls_t                          entry_reg [adnp_pkg::QUEUE_DEPTH];
    logic [adnp_pkg::QUEUE_PTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [adnp_pkg::QUEUE_PTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [adnp_pkg::QUEUE_CNT_BITS-1:0]     count_reg, count_next;
    logic                                    push, pop;

    assign status.full  = (count_reg == adnp_pkg::QUEUE_CNT_BITS'(adnp_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];
    assign push         = push_valid && push_ready;
    assign pop          = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/adnp_back.sv
// ----------------------------------------------------------------------------
// adnp_back
// Parser back end: phase tracking, accumulation and result output register.
// ----------------------------------------------------------------------------
module adnp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [1:0]             variant,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  adnp_pkg::cls_t         item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output adnp_pkg::out_t         result,
    output adnp_pkg::back_status_t status
);

    logic [1:0]                       phase_reg, phase_next;
    logic                             comment_reg, comment_next;
    logic [adnp_pkg::VALUE_BITS-1:0]  acc_reg, acc_next;
    logic                             wrap_reg, wrap_next;
    logic                             out_valid_reg;
    adnp_pkg::out_t                   out_reg;
    logic                             pend_valid_reg;
    adnp_pkg::out_t                   pend_reg;

    logic [adnp_pkg::VALUE_BITS+3:0]  acc_wide;
    logic                             acc_ovf;
    logic [1:0]                       res_cnt;
    adnp_pkg::out_t                   res0, res1;
    adnp_pkg::out_t                   done_res;
    logic                             var_comments;
    logic                             out_free;
    logic                             take;

    // value*10 + digit, with the carry-out bits flagging a wrap
    assign acc_wide = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + (adnp_pkg::VALUE_BITS+4)'(item.digit);
    assign acc_ovf  = |acc_wide[adnp_pkg::VALUE_BITS+3:adnp_pkg::VALUE_BITS];

    assign var_comments = (variant == adnp_pkg::VAR_COMMENTS);
    assign done_res     = adnp_pkg::make_result(adnp_pkg::low_word(acc_reg),
                                                adnp_pkg::ST_OK, wrap_reg, 1'b0);

    assign out_free   = !out_valid_reg || result_ready;
    assign item_ready = !pend_valid_reg && out_free;
    assign take       = item_valid && item_ready;

    always_comb
    begin
        phase_next   = phase_reg;
        comment_next = comment_reg;
        acc_next     = acc_reg;
        wrap_next    = wrap_reg;
        res_cnt      = 2'd0;
        res0         = done_res;
        res1         = adnp_pkg::make_result(32'd0, adnp_pkg::ST_NOT_DIGIT, 1'b0, 1'b1);

        if (item.eod)
        begin
            if (phase_reg == adnp_pkg::PH_LEADER)
            begin
                res0 = adnp_pkg::make_result(32'd0, adnp_pkg::ST_EMPTY, 1'b0, 1'b0);
            end
            res_cnt      = 2'd1;
            comment_next = 1'b0;
            phase_next   = adnp_pkg::PH_LEADER;
            acc_next     = '0;
            wrap_next    = 1'b0;
        end
        else if (var_comments && comment_reg)
        begin
            if (item.is_newline)
            begin
                comment_next = 1'b0;
            end
        end
        else if (var_comments && item.is_hash)
        begin
            comment_next = 1'b1;
        end
        else
        begin
            case (phase_reg)
                adnp_pkg::PH_DIGITS:
                begin
                    if (item.is_space)
                    begin
                        if (variant == adnp_pkg::VAR_STOP_SPACE)
                        begin
                            res_cnt    = 2'd1;
                            phase_next = adnp_pkg::PH_LEADER;
                            acc_next   = '0;
                            wrap_next  = 1'b0;
                        end
                        else
                        begin
                            phase_next = adnp_pkg::PH_TRAILS;
                        end
                    end
                    else if (item.is_digit)
                    begin
                        acc_next  = acc_wide[adnp_pkg::VALUE_BITS-1:0];
                        wrap_next = wrap_reg | acc_ovf;
                    end
                    else
                    begin
                        res0       = res1;
                        res_cnt    = 2'd1;
                        phase_next = adnp_pkg::PH_LEADER;
                        acc_next   = '0;
                        wrap_next  = 1'b0;
                    end
                end
                adnp_pkg::PH_TRAILS:
                begin
                    // Non-space ends the number; a digit starts the next one, any other byte adds a not-digit result
                    if (!item.is_space)
                    begin
                        wrap_next = 1'b0;
                        if (item.is_digit)
                        begin
                            res_cnt    = 2'd1;
                            phase_next = adnp_pkg::PH_DIGITS;
                            acc_next   = adnp_pkg::VALUE_BITS'(item.digit);
                        end
                        else
                        begin
                            res_cnt    = 2'd2;
                            phase_next = adnp_pkg::PH_LEADER;
                            acc_next   = '0;
                        end
                    end
                end
                default:
                begin
                    if (!item.is_space)
                    begin
                        wrap_next = 1'b0;
                        if (item.is_digit)
                        begin
                            phase_next = adnp_pkg::PH_DIGITS;
                            acc_next   = adnp_pkg::VALUE_BITS'(item.digit);
                        end
                        else
                        begin
                            res0       = res1;
                            res_cnt    = 2'd1;
                            phase_next = adnp_pkg::PH_LEADER;
                            acc_next   = '0;
                        end
                    end
                end
            endcase
        end

        res0.last_of_run = (res_cnt == 2'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= adnp_pkg::PH_LEADER;
            comment_reg    <= 1'b0;
            acc_reg        <= '0;
            wrap_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                comment_reg <= comment_next;
                acc_reg     <= acc_next;
                wrap_reg    <= wrap_next;
            end
            if (pend_valid_reg && out_free)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else if (take && res_cnt != 2'd0)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= (res_cnt == 2'd2);
            end
            else if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (pend_valid_reg && out_free)
        begin
            out_reg <= pend_reg;
        end
        else if (take && res_cnt != 2'd0)
        begin
            out_reg  <= res0;
            pend_reg <= res1;
        end
    end

    assign result_valid      = out_valid_reg;
    assign result            = out_reg;
    assign status.pend_valid = pend_valid_reg;
    assign status.take       = take;

endmodule

>>> tb/sv/ascii_decimal_number_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_checker
// Watches the byte, result and configuration ports of the decimal number
// parser, predicts the results of every accepted byte and compares them.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_checker
    import adnp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic       byte_ready,
    input  in_t        byte_item,
    input  logic       result_valid,
    input  logic       result_ready,
    input  out_t       result_item,
    input  logic       cfg_write_en,
    input  logic [1:0] cfg_write_data,
    output int         error_count,
    output int         expected_left
);

    out_t        numbers_due[$];
    logic [1:0]  variant;
    logic [1:0]  phase;
    logic        comment_on;
    logic [63:0] acc_wide;
    logic        wrapped;

    function automatic logic blank(input logic [7:0] b);
        return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
    endfunction

    function automatic logic numeral(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic out_t number_result(input logic [31:0] value,
                                           input logic [1:0]  status,
                                           input logic        ovf);
        out_t r;
        r.number_value = value;
        r.parse_status = status;
        r.overflowed   = ovf;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic clear_number();
        phase    = PH_LEADER;
        acc_wide = '0;
        wrapped  = 1'b0;
    endtask

    task automatic add_digit(input logic [7:0] b);
        logic [63:0] d;
        logic [63:0] span;
        d    = 64'(b - CH_ZERO);
        span = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        if (acc_wide > (span - d) / 64'd10)
            wrapped = 1'b1;
        acc_wide = (acc_wide * 64'd10 + d) & span;
    endtask

    // Leader handling of a non-space byte: a digit opens a number, anything
    // else is a not-digit error.
    task automatic open_number(input logic [7:0] b, output logic failed);
        clear_number();
        failed = !numeral(b);
        if (!failed)
        begin
            phase = PH_DIGITS;
            add_digit(b);
        end
    endtask

    task automatic predict_parse(input in_t item);
        out_t       res [0:1];
        int         n;
        logic [7:0] b;
        logic       failed;
        n = 0;
        b = item.byte_in;
        if (item.end_of_data)
        begin
            if (phase != PH_LEADER)
                res[0] = number_result(acc_wide[31:0], ST_OK, wrapped);
            else
                res[0] = number_result('0, ST_EMPTY, 1'b0);
            n = 1;
            comment_on = 1'b0;
            clear_number();
        end
        else if (variant == VAR_COMMENTS && comment_on)
        begin
            if (b == CH_NEWLINE)
                comment_on = 1'b0;
        end
        else if (variant == VAR_COMMENTS && b == CH_HASH)
        begin
            comment_on = 1'b1;
        end
        else if (phase == PH_DIGITS)
        begin
            if (blank(b))
            begin
                if (variant == VAR_STOP_SPACE)
                begin
                    res[n] = number_result(acc_wide[31:0], ST_OK, wrapped);
                    n++;
                    clear_number();
                end
                else
                    phase = PH_TRAILS;
            end
            else if (numeral(b))
                add_digit(b);
            else
            begin
                clear_number();
                res[n] = number_result('0, ST_NOT_DIGIT, 1'b0);
                n++;
            end
        end
        else if (!blank(b))
        begin
            // a byte that ends a trailing run first closes the number
            if (phase == PH_TRAILS)
            begin
                res[n] = number_result(acc_wide[31:0], ST_OK, wrapped);
                n++;
            end
            open_number(b, failed);
            if (failed)
            begin
                res[n] = number_result('0, ST_NOT_DIGIT, 1'b0);
                n++;
            end
        end
        if (n > 0)
            res[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++)
            numbers_due.push_back(res[i]);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numbers_due.delete();
            variant       = VAR_SKIP_TRAIL;
            comment_on    = 1'b0;
            clear_number();
            error_count   = 0;
            expected_left = 0;
        end
        else
        begin
            if (cfg_write_en)
                variant = cfg_write_data;
            if (result_valid && result_ready)
            begin
                if (numbers_due.size() == 0)
                begin
                    $error("result with none expected: value %0d status %0d",
                           result_item.number_value, result_item.parse_status);
                    error_count++;
                end
                else
                begin
                    out_t want;
                    want = numbers_due.pop_front();
                    check_field("number_value", want.number_value,
                                result_item.number_value);
                    check_field("parse_status", 32'(want.parse_status),
                                32'(result_item.parse_status));
                    check_field("overflowed", 32'(want.overflowed),
                                32'(result_item.overflowed));
                    check_field("last_of_run", 32'(want.last_of_run),
                                32'(result_item.last_of_run));
                end
            end
            if (byte_valid && byte_ready)
                predict_parse(byte_item);
            expected_left = numbers_due.size();
        end
    end

endmodule

>>> tb/sv/ascii_decimal_number_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_number_parser_test
// Drives text bytes and end-of-data marks into the decimal number parser
// under every variant, with random gaps on both channels, and leaves the
// checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_test;
    import adnp_pkg::*;

    // the fourth register code carries no meaning of its own
    localparam logic [1:0] VAR_SPARE = 2'd3;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       byte_valid     = 1'b0;
    logic       byte_ready;
    in_t        byte_item      = '0;
    logic       result_valid;
    logic       result_ready   = 1'b0;
    out_t       result_item;
    logic       cfg_write_en   = 1'b0;
    logic [1:0] cfg_write_data = '0;

    // steady turns all idling off on both sides for one stretch of the run
    logic       steady         = 1'b0;
    logic [1:0] variant_now    = VAR_SKIP_TRAIL;
    int         counted        = 0;
    int         error_count;
    int         expected_left;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ascii_decimal_number_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_item      (byte_item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_item    (result_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    ascii_decimal_number_parser_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_item      (byte_item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result_item    (result_item),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .error_count    (error_count),
        .expected_left  (expected_left)
    );

    // Stall the result side about 7 percent of the time, except when steady.
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(0, 99) >= 7);

    // Hand one transaction to the block. Enter and leave at a rising edge;
    // ready is sampled at the falling edge, where every input is settled, so
    // the next rising edge is the one that accepts the transaction.
    task automatic push_item(input logic [7:0] b, input logic eod);
        in_t item;
        item.byte_in     = b;
        item.end_of_data = eod;
        while (!steady && $urandom_range(0, 99) < 7)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= item;
        do
            @(negedge clk);
        while (!byte_ready);
        @(posedge clk);
        counted++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        push_item(b, 1'b0);
    endtask

    task automatic send_end(input logic [7:0] junk);
        push_item(junk, 1'b1);
    endtask

    function automatic logic [7:0] blank_byte();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    // Drop valid and hold until every expected result has come out, then
    // let the pipeline drain the bytes that produce nothing.
    task automatic settle();
        byte_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_left != 0);
        repeat (6) @(posedge clk);
    endtask

    // Write the variant register while the block is idle.
    task automatic write_variant(input logic [1:0] v);
        settle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        variant_now    <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // One random token: mostly well-formed numbers with random digits and
    // separators, some comments, plus noise bytes and stream ends.
    task automatic random_token();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            repeat ($urandom_range(0, 2)) send_byte(blank_byte());
            // mostly short numbers; now and then long enough to wrap
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                              : $urandom_range(1, 6);
            repeat (len) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(1, 3)) send_byte(blank_byte());
        end
        else if (pick < 82 || (variant_now == VAR_COMMENTS && pick < 88))
        begin
            send_byte(CH_HASH);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NEWLINE);
        end
        else if (pick < 95)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_end(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int target;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: skip-trailing variant first.
        write_variant(VAR_SKIP_TRAIL);
        send_end(8'hFF);            // end of data with nothing started
        send_byte("7");
        send_byte(CH_SPACE);
        send_byte(CH_TAB);
        send_byte("A");             // closes 7, then fails as a new start
        send_byte(8'h00);           // non-digit in the leader phase
        send_byte("3");
        send_byte(CH_CR);           // leave 3 waiting in the trails phase

        // Switch to stop-at-space while a number sits in the trails phase.
        write_variant(VAR_STOP_SPACE);
        send_byte("5");             // closes 3 and starts 5
        send_byte(CH_SPACE);        // first space ends 5 right away
        send_byte(CH_HASH);         // a hash is just a non-digit here

        // Comments inside a number vanish and the digits around them join.
        write_variant(VAR_COMMENTS);
        send_byte("1");
        send_byte(CH_HASH);
        send_byte("x");
        send_byte(CH_NEWLINE);
        send_byte("2");
        send_byte(CH_SPACE);
        send_end(8'h00);
        send_byte(CH_HASH);         // leave the comment flag set

        // Spare code: the flag is kept but ignored.
        write_variant(VAR_SPARE);
        send_byte("4");
        send_byte(CH_SPACE);
        send_byte("x");

        // Back in comment mode the old flag still swallows bytes.
        write_variant(VAR_COMMENTS);
        send_byte("5");
        send_byte(CH_NEWLINE);
        send_end(8'hA5);

        // Random part: several phases, each under its own variant.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_variant(ph == 0 ? VAR_COMMENTS : 2'($urandom_range(0, 3)));
            steady <= (ph == 2);
            target = counted + 85;
            while (counted < target)
                random_token();
        end

        steady <= 1'b0;
        settle();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Timeout guard: far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
